/* rtl/drf_pkg.sv */
// ----------------------------------------------------------------------------
// drf_pkg
// shared types and constants of the dual ring fifo with transfer
// ----------------------------------------------------------------------------
package drf_pkg;

    localparam int CFG_W    = 5;   // capacity register
    localparam int VALUE_W  = 32;  // write_value / read_value
    localparam int COUNT_W  = 8;   // move count
    localparam int ACTION_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT  = 2'd0,
        ACT_EXTRACT = 2'd1,
        ACT_MOVE    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;     // capture the incoming item
        logic push;      // insert into the selected buffer
        logic pop;       // extract from the selected buffer
        logic xfer_rd;   // move: pop the source
        logic xfer_wr;   // move: push the popped value into the other buffer
        logic fail;      // action failed, clear ok
        logic load_out;  // load the result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        action_t action;
        logic    src_empty;
        logic    src_full;
        logic    dst_full;
        logic    rem_zero;
    } status_t;

endpackage

/* rtl/drf_ctrl.sv */
// ----------------------------------------------------------------------------
// drf_ctrl
// sequencer for insert, extract and move, plus the result handshake
// ----------------------------------------------------------------------------
module drf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  drf_pkg::status_t status,
    output drf_pkg::cmd_t    cmd
);
    import drf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOVE_WR,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESULT;
                unique case (status.action)
                    ACT_INSERT:
                    begin
                        if (status.src_full)
                        begin
                            cmd.fail = 1'b1;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    ACT_EXTRACT:
                    begin
                        if (status.src_empty)
                        begin
                            cmd.fail = 1'b1;
                        end
                        else
                        begin
                            cmd.pop = 1'b1;
                        end
                    end
                    ACT_MOVE:
                    begin
                        priority if (status.rem_zero)
                        begin
                            state_next = ST_RESULT;
                        end
                        else if (status.src_empty || status.dst_full)
                        begin
                            cmd.fail = 1'b1;
                        end
                        else
                        begin
                            cmd.xfer_rd = 1'b1;
                            state_next  = ST_MOVE_WR;
                        end
                    end
                    ACT_NONE:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_MOVE_WR:
            begin
                cmd.xfer_wr = 1'b1;
                state_next  = ST_EXEC;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    in_ready       = 1'b1;
                    if (in_valid)
                    begin
                        cmd.latch  = 1'b1;
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/drf_datapath.sv */
// ----------------------------------------------------------------------------
// drf_datapath
// two ring stores with pointers, fill counts, capacity and result register
// ----------------------------------------------------------------------------
module drf_datapath #(
    parameter int MAX_DEPTH  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [drf_pkg::CFG_W-1:0]   cfg_data,
    input  logic [drf_pkg::ACTION_W-1:0] in_action,
    input  logic                        in_sel,
    input  logic [drf_pkg::VALUE_W-1:0] in_value,
    input  logic [drf_pkg::COUNT_W-1:0] in_count,
    input  drf_pkg::cmd_t               cmd,
    output drf_pkg::status_t            status,
    output logic                        out_ok,
    output logic [drf_pkg::VALUE_W-1:0] out_value,
    output logic                        out_full,
    output logic                        out_empty
);
    import drf_pkg::*;

    localparam int PTR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CAP_W-1:0] MAX_CAP = CAP_W'(MAX_DEPTH);

    logic [DATA_WIDTH-1:0] store_a [MAX_DEPTH];
    logic [DATA_WIDTH-1:0] store_b [MAX_DEPTH];
    logic [DATA_WIDTH-1:0] rd_a_reg, rd_b_reg;

    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [PTR_W-1:0] wr_ptr_reg [2];
    logic [PTR_W-1:0] wr_ptr_next [2];
    logic [PTR_W-1:0] rd_ptr_reg [2];
    logic [PTR_W-1:0] rd_ptr_next [2];
    logic [CNT_W-1:0] fill_reg [2];
    logic [CNT_W-1:0] fill_next [2];
    logic             full_b [2];
    logic             empty_b [2];

    action_t              act_reg;
    logic                 sel_reg;
    logic [VALUE_W-1:0]   wval_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic                 ok_reg;

    logic [DATA_WIDTH-1:0] src_rd;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [PTR_W-1:0]      src_rd_ptr, dst_wr_ptr;
    logic                  wr_a, wr_b, rd_a, rd_b;

    // next slot of a ring, wrapping at the configured capacity
    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] n;
        n = CAP_W'(p) + CAP_W'(1);
        return (n >= cap) ? '0 : PTR_W'(n);
    endfunction

    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            full_b[b]  = CAP_W'(fill_reg[b]) >= cap_reg;
            empty_b[b] = fill_reg[b] == '0;
        end
    end

    assign status.action    = act_reg;
    assign status.src_empty = sel_reg ? empty_b[1] : empty_b[0];
    assign status.src_full  = sel_reg ? full_b[1] : full_b[0];
    assign status.dst_full  = sel_reg ? full_b[0] : full_b[1];
    assign status.rem_zero  = rem_reg == '0;

    // capacity write clamps to 1..MAX_DEPTH
    always_comb
    begin
        cap_next = CAP_W'(cfg_data);
        priority if (cap_next == '0)
        begin
            cap_next = CAP_W'(1);
        end
        else if (cap_next > MAX_CAP)
        begin
            cap_next = MAX_CAP;
        end
    end

    // pointer and fill count updates, buffer b is source when sel matches
    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            logic is_src, do_push, do_pop;
            is_src  = sel_reg == b[0];
            do_push = (cmd.push && is_src) || (cmd.xfer_wr && !is_src);
            do_pop  = (cmd.pop || cmd.xfer_rd) && is_src;
            wr_ptr_next[b] = do_push ? ptr_adv(wr_ptr_reg[b], cap_reg) : wr_ptr_reg[b];
            rd_ptr_next[b] = do_pop ? ptr_adv(rd_ptr_reg[b], cap_reg) : rd_ptr_reg[b];
            fill_next[b]   = fill_reg[b];
            if (do_push)
            begin
                fill_next[b] = fill_reg[b] + CNT_W'(1);
            end
            else if (do_pop)
            begin
                fill_next[b] = fill_reg[b] - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(1);
            for (int b = 0; b < 2; b++)
            begin
                wr_ptr_reg[b] <= '0;
                rd_ptr_reg[b] <= '0;
                fill_reg[b]   <= '0;
            end
        end
        else if (cfg_valid)
        begin
            cap_reg <= cap_next;
            for (int b = 0; b < 2; b++)
            begin
                wr_ptr_reg[b] <= '0;
                rd_ptr_reg[b] <= '0;
                fill_reg[b]   <= '0;
            end
        end
        else
        begin
            for (int b = 0; b < 2; b++)
            begin
                wr_ptr_reg[b] <= wr_ptr_next[b];
                rd_ptr_reg[b] <= rd_ptr_next[b];
                fill_reg[b]   <= fill_next[b];
            end
        end
    end

    // item capture and ok flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else if (cmd.latch)
        begin
            ok_reg <= action_t'(in_action) != ACT_NONE;
        end
        else if (cmd.fail)
        begin
            ok_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg  <= action_t'(in_action);
            sel_reg  <= in_sel;
            wval_reg <= in_value;
            rem_reg  <= in_count;
        end
        else if (cmd.xfer_wr)
        begin
            rem_reg <= rem_reg - COUNT_W'(1);
        end
    end

    // ring stores, one write and one registered read each
    assign src_rd     = sel_reg ? rd_b_reg : rd_a_reg;
    assign src_rd_ptr = sel_reg ? rd_ptr_reg[1] : rd_ptr_reg[0];
    assign dst_wr_ptr = (cmd.xfer_wr ^ sel_reg) ? wr_ptr_reg[1] : wr_ptr_reg[0];
    assign wr_data    = cmd.xfer_wr ? src_rd : DATA_WIDTH'(wval_reg);
    assign wr_a       = (cmd.push && !sel_reg) || (cmd.xfer_wr && sel_reg);
    assign wr_b       = (cmd.push && sel_reg) || (cmd.xfer_wr && !sel_reg);
    assign rd_a       = (cmd.pop || cmd.xfer_rd) && !sel_reg;
    assign rd_b       = (cmd.pop || cmd.xfer_rd) && sel_reg;

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            store_a[dst_wr_ptr] <= wr_data;
        end
        if (rd_a)
        begin
            rd_a_reg <= store_a[src_rd_ptr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            store_b[dst_wr_ptr] <= wr_data;
        end
        if (rd_b)
        begin
            rd_b_reg <= store_b[src_rd_ptr];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_ok    <= ok_reg;
            out_value <= (act_reg == ACT_EXTRACT && ok_reg) ? VALUE_W'(src_rd) : '0;
            out_full  <= status.src_full;
            out_empty <= status.src_empty;
        end
    end

endmodule

/* rtl/dual_ring_fifo_with_transfer.sv */
// ----------------------------------------------------------------------------
// dual_ring_fifo_with_transfer
// two ring fifos sharing one capacity, with insert, extract and move actions
// ----------------------------------------------------------------------------
// Each input transfer picks a buffer (tuser bit 2) and an action (tuser bits
// 1:0): insert pushes tdata[31:0] unless the buffer is full, extract pops the
// oldest value unless it is empty, move shifts up to tdata[39:32] values one
// by one into the other buffer and stops with ok low at the first empty
// source or full destination, leaving values already moved in place. Every
// input transfer gives exactly one output transfer with ok, the popped value
// and the full and empty flags of the selected buffer after the action.
// A move handles its values one at a time: each is one registered read of the
// source store followed by one write of the destination store. The next
// item is taken while a result still waits in the output register. Writing
// capacity (clamped to 1..MAX_DEPTH) empties both buffers; the user must only
// do it while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module dual_ring_fifo_with_transfer #(
    parameter int MAX_DEPTH  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: capacity
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // write_value[31:0], count[39:32]
    input  logic [2:0]  s_axis_tuser,   // action[1:0], buffer_sel[2]
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // read_value[31:0]
    output logic [2:0]  m_axis_tuser    // ok[0], is_full[1], is_empty[2]
);
    import drf_pkg::*;

    cmd_t    cmd;
    status_t status;

    logic                out_ok, out_full, out_empty;
    logic [VALUE_W-1:0]  out_value;

    // capacity writes are always taken
    assign cfg_ready = 1'b1;

    drf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    drf_datapath #(
        .MAX_DEPTH  (MAX_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_action (s_axis_tuser[1:0]),
        .in_sel    (s_axis_tuser[2]),
        .in_value  (s_axis_tdata[31:0]),
        .in_count  (s_axis_tdata[39:32]),
        .cmd       (cmd),
        .status    (status),
        .out_ok    (out_ok),
        .out_value (out_value),
        .out_full  (out_full),
        .out_empty (out_empty)
    );

    // result packing
    assign m_axis_tdata = out_value;
    assign m_axis_tuser = {out_empty, out_full, out_ok};

    // never push into a full buffer
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !status.src_full)
        else $error("push issued into a full buffer");

    // a move step only starts with a value to take and room to put it
    a_move_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.xfer_rd |-> (!status.src_empty && !status.dst_full))
        else $error("move step started without source data or destination room");

    // a waiting result is never overwritten
    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register loaded while a result was waiting");

    // after a capacity write the source is empty and the destination is not full
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (status.src_empty && !status.dst_full))
        else $error("buffers not empty after capacity write");

endmodule

/* verif/dual_ring_fifo_with_transfer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_ring_fifo_with_transfer_tb
// self-checking bench for the dual ring fifo with insert, extract and move
// ----------------------------------------------------------------------------
// Runs a short directed table at the reset capacity and then random phases,
// one per capacity setting (in-range values, the extremes and clamped values).
// Every accepted input transfer is run through a behavioral copy of the two
// rings and the expected result is queued. Output transfers are compared in
// order, field by field. Both stream sides idle at random, and the receiver
// holds off once for a long stretch so the block backs up and stalls input.
// ----------------------------------------------------------------------------
module dual_ring_fifo_with_transfer_tb;

    import drf_pkg::*;

    localparam int RING_SLOTS  = 16;
    localparam int SETTLE      = 40;      // longest move plus margin
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 76;
    localparam int NUM_PHASES  = 9;
    localparam int HOLD_CYCLES = 80;

    // one input item, field order as in the work of the block
    typedef struct packed {
        action_t     act;
        logic        sel;
        logic [31:0] value;
        logic [7:0]  count;
    } fifo_cmd_t;

    // one result item
    typedef struct packed {
        logic        ok;
        logic [31:0] rd;
        logic        full;
        logic        empty;
    } fifo_resp_t;

    // directed row: the item, and a hand-typed result where typed is set
    typedef struct packed {
        fifo_cmd_t  cmd;
        logic       typed;
        fifo_resp_t resp;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // write_value[31:0], count[39:32]
    logic [2:0]  s_axis_tuser;   // action[1:0], buffer_sel[2]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // read_value[31:0]
    logic [2:0]  m_axis_tuser;   // ok[0], is_full[1], is_empty[2]

    dual_ring_fifo_with_transfer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------
    // shadow copy of the two rings
    // ------------------------------------------------------------------
    logic [31:0] ring_mem [2][RING_SLOTS];
    int unsigned wr_idx [2];
    int unsigned rd_idx [2];
    int unsigned level [2];
    int unsigned cap = 1;

    fifo_resp_t  resp_due [$];    // results owed by the block, oldest first

    int          err_count = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          moves_sent = 0;
    int          failed_due = 0;
    int          cycle_count = 0;

    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    bit          hold_req = 1'b0;
    bit          hold_taken = 1'b0;

    // ring index wrap at the configured capacity
    function automatic int unsigned next_slot(input int unsigned p);
        return (p + 1 >= cap) ? 0 : p + 1;
    endfunction

    // works out the result of one item and advances the shadow rings
    function automatic fifo_resp_t ring_predict(input fifo_cmd_t c);
        fifo_resp_t  r;
        int unsigned s;
        int unsigned d;
        int          n;
        logic [31:0] t;
        r = '0;
        s = 32'(c.sel);
        d = s ^ 1;
        case (c.act)
            ACT_INSERT:
                if (level[s] < cap)
                begin
                    ring_mem[s][wr_idx[s]] = c.value;
                    wr_idx[s] = next_slot(wr_idx[s]);
                    level[s]++;
                    r.ok = 1'b1;
                end
            ACT_EXTRACT:
                if (level[s] != 0)
                begin
                    r.rd = ring_mem[s][rd_idx[s]];
                    rd_idx[s] = next_slot(rd_idx[s]);
                    level[s]--;
                    r.ok = 1'b1;
                end
            ACT_MOVE:
            begin
                // check source and destination before every single value
                r.ok = 1'b1;
                for (n = 0; n < int'(c.count) && r.ok; n++)
                begin
                    if (level[s] == 0 || level[d] >= cap)
                        r.ok = 1'b0;
                    else
                    begin
                        t = ring_mem[s][rd_idx[s]];
                        rd_idx[s] = next_slot(rd_idx[s]);
                        level[s]--;
                        ring_mem[d][wr_idx[d]] = t;
                        wr_idx[d] = next_slot(wr_idx[d]);
                        level[d]++;
                    end
                end
            end
            default: ;  // unused action leaves everything as it is
        endcase
        r.full  = (level[s] >= cap);
        r.empty = (level[s] == 0);
        return r;
    endfunction

    function automatic directed_row_t mk_row(
        input action_t a, input logic s, input logic [31:0] v, input logic [7:0] n,
        input logic typed, input logic ok, input logic [31:0] rd,
        input logic full, input logic empty);
        directed_row_t row;
        row.cmd   = '{act: a, sel: s, value: v, count: n};
        row.typed = typed;
        row.resp  = '{ok: ok, rd: rd, full: full, empty: empty};
        return row;
    endfunction

    // ------------------------------------------------------------------
    // clock and cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still owed",
                 cycle_count, resp_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offers one item with a random lead-in gap, returns once it is taken
    task automatic offer_item(input fifo_cmd_t c);
        while (tx_idle_en && $urandom_range(99) < 38)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c.count, c.value};
        s_axis_tuser  <= {c.sel, c.act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (c.act == ACT_MOVE)
            moves_sent++;
    endtask

    // stop offering, let every owed result come out, then let a move finish
    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        while (resp_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // capacity write, only while the block is idle; also empties both rings
    task automatic write_capacity(input logic [4:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (v == 0)
            cap = 1;
        else if (v > RING_SLOTS)
            cap = RING_SLOTS;
        else
            cap = 32'(v);
        wr_idx = '{0, 0};
        rd_idx = '{0, 0};
        level  = '{0, 0};
    endtask

    // ------------------------------------------------------------------
    // output side: ready pattern, with one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : rx_ready_gen
        int  hold_left;
        bit  rdy;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (!rx_idle_en)
                rdy = 1'b1;
            else
                rdy = ($urandom_range(99) >= 38);
            m_axis_tready <= rdy;
        end
    end

    // compare every output transfer with the oldest owed result
    always @(posedge clk)
    begin : result_check
        fifo_resp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (resp_due.size() == 0)
            begin
                $error("result with nothing owed: ok %0b read_value %h", m_axis_tuser[0],
                       m_axis_tdata);
                err_count++;
            end
            else
            begin
                want = resp_due.pop_front();
                if (m_axis_tuser[0] !== want.ok)
                begin
                    $error("ok: expected %0b, actual %0b", want.ok, m_axis_tuser[0]);
                    err_count++;
                end
                if (m_axis_tdata !== want.rd)
                begin
                    $error("read_value: expected %h, actual %h", want.rd, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tuser[1] !== want.full)
                begin
                    $error("is_full: expected %0b, actual %0b", want.full, m_axis_tuser[1]);
                    err_count++;
                end
                if (m_axis_tuser[2] !== want.empty)
                begin
                    $error("is_empty: expected %0b, actual %0b", want.empty, m_axis_tuser[2]);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        directed_row_t dir_tbl [$];
        logic [4:0]    cap_plan [NUM_PHASES];
        fifo_cmd_t     c;
        fifo_resp_t    r;
        int            i;
        int            ph;
        int            roll;
        bit            fill_half;

        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;

        // in range, both extremes and values that get clamped
        cap_plan = '{5'd16, 5'd0, 5'd5, 5'd31, 5'd2, 5'd17, 5'd9, 5'd1, 5'd3};

        // reset capacity is one entry per ring
        // typed rows: empty rings after reset, zero move, empty source,
        // unused action, single slot full and refused insert
        dir_tbl.push_back(mk_row(ACT_EXTRACT, 1'b0, 32'h0, 8'd0,   1, 0, 32'h0, 0, 1));
        dir_tbl.push_back(mk_row(ACT_EXTRACT, 1'b1, 32'h0, 8'd0,   1, 0, 32'h0, 0, 1));
        dir_tbl.push_back(mk_row(ACT_MOVE,    1'b0, 32'h0, 8'd0,   1, 1, 32'h0, 0, 1));
        dir_tbl.push_back(mk_row(ACT_MOVE,    1'b1, 32'h0, 8'd255, 1, 0, 32'h0, 0, 1));
        dir_tbl.push_back(mk_row(ACT_NONE,    1'b0, 32'hFFFF_FFFF, 8'd255,
                                 1, 0, 32'h0, 0, 1));
        dir_tbl.push_back(mk_row(ACT_INSERT,  1'b0, 32'h8000_0000, 8'd0,
                                 1, 1, 32'h0, 1, 0));
        dir_tbl.push_back(mk_row(ACT_INSERT,  1'b0, 32'h7FFF_FFFF, 8'd0,
                                 1, 0, 32'h0, 1, 0));
        dir_tbl.push_back(mk_row(ACT_NONE,    1'b0, 32'h0, 8'd0,   1, 0, 32'h0, 1, 0));
        // predicted rows: moves into a free and into a full ring, pops
        dir_tbl.push_back(mk_row(ACT_MOVE,    1'b0, 32'h0, 8'd1,   0, 0, 32'h0, 0, 0));
        dir_tbl.push_back(mk_row(ACT_INSERT,  1'b0, 32'hFFFF_FFFF, 8'd0,
                                 0, 0, 32'h0, 0, 0));
        dir_tbl.push_back(mk_row(ACT_MOVE,    1'b0, 32'h0, 8'd1,   0, 0, 32'h0, 0, 0));
        dir_tbl.push_back(mk_row(ACT_EXTRACT, 1'b1, 32'h0, 8'd0,   0, 0, 32'h0, 0, 0));
        dir_tbl.push_back(mk_row(ACT_EXTRACT, 1'b0, 32'h0, 8'd0,   0, 0, 32'h0, 0, 0));
        dir_tbl.push_back(mk_row(ACT_INSERT,  1'b1, 32'h0, 8'd0,   0, 0, 32'h0, 0, 0));
        dir_tbl.push_back(mk_row(ACT_INSERT,  1'b1, 32'h7FFF_FFFF, 8'd0,
                                 0, 0, 32'h0, 0, 0));
        dir_tbl.push_back(mk_row(ACT_MOVE,    1'b1, 32'h0, 8'd255, 0, 0, 32'h0, 0, 0));
        dir_tbl.push_back(mk_row(ACT_EXTRACT, 1'b0, 32'h0, 8'd0,   0, 0, 32'h0, 0, 0));
        dir_tbl.push_back(mk_row(ACT_INSERT,  1'b0, 32'h5555_5555, 8'd0,
                                 0, 0, 32'h0, 0, 0));
        dir_tbl.push_back(mk_row(ACT_EXTRACT, 1'b0, 32'h0, 8'd0,   0, 0, 32'h0, 0, 0));
        dir_tbl.push_back(mk_row(ACT_INSERT,  1'b1, 32'hAAAA_AAAA, 8'd0,
                                 0, 0, 32'h0, 0, 0));
        dir_tbl.push_back(mk_row(ACT_EXTRACT, 1'b1, 32'h0, 8'd0,   0, 0, 32'h0, 0, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < dir_tbl.size(); i++)
        begin
            offer_item(dir_tbl[i].cmd);
            r = ring_predict(dir_tbl[i].cmd);
            if (dir_tbl[i].typed)
                r = dir_tbl[i].resp;
            if (!r.ok)
                failed_due++;
            resp_due.push_back(r);
        end
        drain_results();

        // random phases, one per capacity setting
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_capacity(cap_plan[ph]);
            // one phase runs back to back on both sides
            tx_idle_en = (ph != 3);
            rx_idle_en = (ph != 3);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // long output hold-off early in the deepest phase
                if (ph == 0 && i == 20)
                    hold_req = 1'b1;
                // fill during the first half, drain during the second
                fill_half = (i < PHASE_ITEMS / 2);
                roll = $urandom_range(99);
                if (roll < (fill_half ? 50 : 20))
                    c.act = ACT_INSERT;
                else if (roll < 70)
                    c.act = ACT_EXTRACT;
                else if (roll < 94)
                    c.act = ACT_MOVE;
                else
                    c.act = ACT_NONE;
                c.sel = 1'($urandom_range(1));
                roll = $urandom_range(99);
                case (roll % 8)
                    0:       c.value = 32'h8000_0000;
                    1:       c.value = 32'h7FFF_FFFF;
                    2:       c.value = (roll < 50) ? 32'h0 : 32'hFFFF_FFFF;
                    default: c.value = $urandom;
                endcase
                roll = $urandom_range(99);
                if (roll < 70)
                    c.count = 8'($urandom_range(3));
                else if (roll < 90)
                    c.count = 8'($urandom_range(18, 4));
                else
                    c.count = 8'($urandom_range(255));
                offer_item(c);
                r = ring_predict(c);
                if (!r.ok)
                    failed_due++;
                resp_due.push_back(r);
            end
            drain_results();
        end

        $display("covered %0d items (%0d moves, %0d refused) over %0d capacity settings",
                 items_sent, moves_sent, failed_due, NUM_PHASES + 1);
        $display("checked %0d results, long output hold-off %s, %0d mismatches",
                 results_seen, hold_taken ? "done" : "missed", err_count);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/drf_pkg.sv
rtl/drf_ctrl.sv
rtl/drf_datapath.sv
rtl/dual_ring_fifo_with_transfer.sv
verif/dual_ring_fifo_with_transfer_tb.sv
